[rtl/mfmt_pkg.sv]
// Shared types and constants for the motor feedback multi-turn tracker.
// Used by mfmt_unwrap, mfmt_scale and motor_feedback_multiturn_tracker_top.
// No dependencies.
package mfmt_pkg;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_BIAS_OFFSET  = 2'd0,
		REG_TORQUE_CONST = 2'd1,
		REG_MOTOR_SERIES = 2'd2
	} reg_idx_t;

	localparam logic [23:0] TORQUE_CONST_RST = 24'd43583;

	// Position unwrap
	localparam logic signed [17:0] HALF_TURN  = 18'sd32768;
	localparam logic signed [17:0] FULL_TURN  = 18'sd65536;
	localparam int                 BIAS_WINDOW = 32700;

	// Frame counter limits
	localparam logic [3:0] FRAME_SAT       = 4'd11;
	localparam logic [3:0] BIAS_LOAD_LAST  = 4'd2;
	localparam logic [3:0] BIAS_TRACK_LAST = 4'd10;

	// Truncating divide of (|speed| * 256) by 6 and by 36 through exact reciprocals:
	// floor(m*256/d) = (m * ceil(2^k/d)) >> (k-8) for all 16-bit m.
	localparam logic [23:0] RECIP_DIV6   = 24'd11184811;  // ceil(2^26/6)
	localparam int          DIV6_SHIFT   = 18;
	localparam logic [23:0] RECIP_DIV36  = 24'd14913081;  // ceil(2^29/36)
	localparam int          DIV36_SHIFT  = 21;

	typedef struct packed {
		logic [15:0] bias_offset;
		logic [23:0] torque_gain;
		logic        motor_series;
	} cfg_t;

	typedef struct packed {
		logic signed [16:0] step_counts;
		logic signed [31:0] turn_count;
		logic signed [47:0] multiturn_position;
		logic signed [47:0] angle_counts;
	} unwrap_res_t;

	typedef struct packed {
		logic signed [23:0] speed_q8;
		logic signed [21:0] rpm_q8;
		logic signed [39:0] torque_q24;
	} scale_res_t;

endpackage

[rtl/mfmt_unwrap.sv]
// Position unwrap, turn counting and start-up bias tracking.
// Holds the per-stream state; updates it on each advanced item.
// Depends on mfmt_pkg.
module mfmt_unwrap (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic [15:0]          position,
	input  mfmt_pkg::cfg_t       cfg,
	output mfmt_pkg::unwrap_res_t res
);

	localparam logic signed [48:0] GapLim = 49'(mfmt_pkg::BIAS_WINDOW);

	logic [3:0]         fc_q, fc_next;
	logic [15:0]        prev_q;
	logic [31:0]        turns_q, turns_next;
	logic signed [17:0] bias_q, bias_cur, bias_next, bias_hi, bias_lo, offs;
	logic signed [17:0] diff;
	logic signed [16:0] step;
	logic [47:0]        mt;
	logic signed [48:0] gap;

	always_comb begin
		fc_next  = (fc_q < mfmt_pkg::FRAME_SAT) ? fc_q + 4'd1 : fc_q;
		offs     = $signed({2'b00, cfg.bias_offset});
		bias_cur = (fc_next <= mfmt_pkg::BIAS_LOAD_LAST) ? offs : bias_q;

		diff = $signed({2'b00, position}) - $signed({2'b00, prev_q});
		if (diff < -mfmt_pkg::HALF_TURN) begin
			turns_next = turns_q + 32'd1;
			step       = 17'(diff + mfmt_pkg::FULL_TURN);
		end else if (diff > mfmt_pkg::HALF_TURN) begin
			turns_next = turns_q - 32'd1;
			step       = 17'(diff - mfmt_pkg::FULL_TURN);
		end else begin
			turns_next = turns_q;
			step       = 17'(diff);
		end

		mt  = {turns_next, position};
		gap = $signed({{31{bias_cur[17]}}, bias_cur}) - $signed({mt[47], mt});

		bias_hi   = offs + mfmt_pkg::FULL_TURN;
		bias_lo   = offs - mfmt_pkg::FULL_TURN;
		bias_next = bias_cur;
		// set the bias one turn above or below the offset, toward the multi-turn position
		if (fc_next <= mfmt_pkg::BIAS_TRACK_LAST) begin
			if (gap < -GapLim)
				bias_next = bias_hi;
			else if (gap > GapLim)
				bias_next = bias_lo;
		end

		res.step_counts        = step;
		res.turn_count         = $signed(turns_next);
		res.multiturn_position = $signed(mt);
		res.angle_counts       = $signed(mt - {{30{bias_cur[17]}}, bias_cur});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q    <= '0;
			prev_q  <= '0;
			turns_q <= '0;
			bias_q  <= '0;
		end else if (advance) begin
			fc_q    <= fc_next;
			prev_q  <= position;
			turns_q <= turns_next;
			bias_q  <= bias_next;
		end
	end

endmodule

[rtl/mfmt_scale.sv]
// Speed, rpm and torque scaling in fixed point.
// Divides by 6 and 36 through reciprocal multipliers; no state.
// Depends on mfmt_pkg.
module mfmt_scale (
	input  logic signed [15:0]  speed,
	input  logic signed [15:0]  current,
	input  mfmt_pkg::cfg_t      cfg,
	output mfmt_pkg::scale_res_t res
);

	logic [15:0] speed_u, spd_abs;
	logic [39:0] prod6, prod36;
	logic [20:0] q6;
	logic [17:0] q36;
	logic [23:0] spd_mag;
	logic [20:0] rpm_mag;
	logic [21:0] rpm_ext;
	logic signed [40:0] torque_full;

	always_comb begin
		speed_u = $unsigned(speed);
		spd_abs = speed[15] ? (~speed_u + 16'd1) : speed_u;

		prod6  = {24'd0, spd_abs} * {16'd0, mfmt_pkg::RECIP_DIV6};
		prod36 = {24'd0, spd_abs} * {16'd0, mfmt_pkg::RECIP_DIV36};
		q6     = prod6[mfmt_pkg::DIV6_SHIFT +: 21];
		q36    = prod36[mfmt_pkg::DIV36_SHIFT +: 18];

		// series 1 takes one extra divide by six on both outputs
		spd_mag = cfg.motor_series ? {3'd0, q6} : {spd_abs, 8'd0};
		rpm_mag = cfg.motor_series ? {3'd0, q36} : q6;
		rpm_ext = {1'b0, rpm_mag};

		res.speed_q8 = speed[15] ? $signed(~spd_mag + 24'd1) : $signed(spd_mag);
		res.rpm_q8   = speed[15] ? $signed(~rpm_ext + 22'd1) : $signed(rpm_ext);

		torque_full    = current * $signed({1'b0, cfg.torque_gain});
		res.torque_q24 = torque_full[39:0];
	end

endmodule

[rtl/motor_feedback_multiturn_tracker_top.sv]
// Motor feedback multi-turn tracker, top level.
// Instantiates mfmt_unwrap and mfmt_scale; depends on mfmt_pkg.
//
// Takes one decoded feedback frame per cycle while out_ready is high and returns
// one result item per frame: frame fields land in an input register, the
// unwrap/bias update and the three reciprocal/torque multipliers work from that
// register, and the result register holds the item until it is taken.
// The turn count, previous position and bias update in the same cycle the item
// moves into the result register, so consecutive frames follow back to back.
// The input side keeps accepting while a result waits, up to one item held in
// each register. Configuration writes are always ready; write them only while
// no frame is in flight. Writes to an index past motor_series are dropped.
module motor_feedback_multiturn_tracker_top (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        position_raw,
	input  logic signed [15:0] speed_raw,
	input  logic signed [15:0] current_raw,
	input  logic [7:0]         temperature_raw,

	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [16:0] step_counts,
	output logic signed [31:0] turn_count,
	output logic signed [47:0] multiturn_position,
	output logic signed [47:0] angle_counts,
	output logic signed [23:0] speed_q8,
	output logic signed [21:0] rpm_q8,
	output logic signed [39:0] torque_q24,
	output logic [7:0]         temperature,

	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data
);

	mfmt_pkg::cfg_t        cfg_q;
	mfmt_pkg::unwrap_res_t unw;
	mfmt_pkg::scale_res_t  scl;

	logic               valid_s1, valid_s2, adv;
	logic [15:0]        pos_s1;
	logic signed [15:0] speed_s1, current_s1;
	logic [7:0]         temp_s1;

	assign cfg_ready = 1'b1;
	assign adv       = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || adv;
	assign out_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bias_offset  <= '0;
			cfg_q.torque_gain  <= mfmt_pkg::TORQUE_CONST_RST;
			cfg_q.motor_series <= 1'b0;
		end else if (cfg_valid) begin
			unique case (mfmt_pkg::reg_idx_t'(cfg_index))
				mfmt_pkg::REG_BIAS_OFFSET:  cfg_q.bias_offset  <= cfg_data[15:0];
				mfmt_pkg::REG_TORQUE_CONST: cfg_q.torque_gain  <= cfg_data;
				mfmt_pkg::REG_MOTOR_SERIES: cfg_q.motor_series <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pos_s1     <= position_raw;
			speed_s1   <= speed_raw;
			current_s1 <= current_raw;
			temp_s1    <= temperature_raw;
		end
	end

	mfmt_unwrap u_unwrap (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (adv),
		.position (pos_s1),
		.cfg      (cfg_q),
		.res      (unw)
	);

	mfmt_scale u_scale (
		.speed   (speed_s1),
		.current (current_s1),
		.cfg     (cfg_q),
		.res     (scl)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv)
			valid_s2 <= 1'b1;
		else if (out_ready)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			step_counts        <= unw.step_counts;
			turn_count         <= unw.turn_count;
			multiturn_position <= unw.multiturn_position;
			angle_counts       <= unw.angle_counts;
			speed_q8           <= scl.speed_q8;
			rpm_q8             <= scl.rpm_q8;
			torque_q24         <= scl.torque_q24;
			temperature        <= temp_s1;
		end
	end

endmodule

[rtl/mfmt_checker.sv]
// Port-level checks for motor_feedback_multiturn_tracker_top.
// Bound to the top level below; no package dependency.
module mfmt_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [16:0] step_counts,
	input logic signed [31:0] turn_count,
	input logic signed [47:0] multiturn_position,
	input logic signed [23:0] speed_q8,
	input logic signed [21:0] rpm_q8
);

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(turn_count)
			&& $stable(multiturn_position) && $stable(step_counts))
		else $error("stalled result item changed");

	a_turns_in_mt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> multiturn_position[47:16] == turn_count)
		else $error("multi-turn position disagrees with turn count");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> step_counts >= -17'sd32768 && step_counts <= 17'sd32768)
		else $error("step beyond half a turn");

	a_rpm_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rpm_q8 != 22'sd0 |-> rpm_q8[21] == speed_q8[23])
		else $error("rpm sign differs from speed sign");

endmodule

bind motor_feedback_multiturn_tracker_top mfmt_checker u_mfmt_checker (.*);
